// ----- rtl/core/sgg_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants, glyph and stroke tables for the stroke glyph generator
package sgg_pkg;

  localparam int NUM_SEGS = 79;

  // reciprocal of 5 scaled by 2^18, exact for dividends below 2^18
  localparam logic [15:0] DIV5_RECIP = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  typedef enum logic {
    OP_MULADD,
    OP_DIV5
  } unit_op_t;

  typedef struct packed {
    unit_op_t    op;
    logic [4:0]  factor;
    logic [11:0] scale;
    logic [3:0]  bias;
    logic [14:0] dividend;
  } unit_req_t;

  typedef enum logic [2:0] {
    REG_SCALE,
    REG_LINE_WIDTH,
    REG_COLOR_RED,
    REG_COLOR_GREEN,
    REG_COLOR_BLUE,
    REG_COLOR_ALPHA
  } reg_index_t;

  typedef struct packed {
    logic       known;
    logic       dot;
    logic [6:0] first;
    logic [3:0] count;
  } glyph_info_t;

  // stroke list, each word is {x0, y0, x1, y1} in twentieths of the cell
  localparam logic [19:0] SEG_TAB [NUM_SEGS] = '{
    // 0
    {5'd2,5'd2,5'd18,5'd2}, {5'd18,5'd2,5'd18,5'd18}, {5'd18,5'd18,5'd2,5'd18},
    {5'd2,5'd18,5'd2,5'd2},
    // 1
    {5'd10,5'd1,5'd10,5'd19}, {5'd6,5'd4,5'd10,5'd1}, {5'd6,5'd19,5'd14,5'd19},
    // 2
    {5'd2,5'd2,5'd18,5'd2}, {5'd18,5'd2,5'd18,5'd10}, {5'd18,5'd10,5'd2,5'd18},
    {5'd2,5'd18,5'd18,5'd18},
    // 3
    {5'd2,5'd2,5'd18,5'd2}, {5'd18,5'd2,5'd18,5'd10}, {5'd8,5'd10,5'd18,5'd10},
    {5'd18,5'd10,5'd18,5'd18}, {5'd2,5'd18,5'd18,5'd18},
    // 4
    {5'd2,5'd2,5'd2,5'd10}, {5'd2,5'd10,5'd18,5'd10}, {5'd14,5'd2,5'd14,5'd19},
    // 5
    {5'd2,5'd2,5'd18,5'd2}, {5'd2,5'd2,5'd2,5'd10}, {5'd2,5'd10,5'd18,5'd10},
    {5'd18,5'd10,5'd18,5'd18}, {5'd2,5'd18,5'd18,5'd18},
    // 6
    {5'd2,5'd2,5'd18,5'd2}, {5'd2,5'd2,5'd2,5'd18}, {5'd2,5'd10,5'd18,5'd10},
    {5'd18,5'd10,5'd18,5'd18}, {5'd2,5'd18,5'd18,5'd18},
    // 7
    {5'd2,5'd2,5'd18,5'd2}, {5'd18,5'd2,5'd6,5'd18},
    // 8
    {5'd2,5'd2,5'd18,5'd2}, {5'd18,5'd2,5'd18,5'd18}, {5'd18,5'd18,5'd2,5'd18},
    {5'd2,5'd18,5'd2,5'd2}, {5'd2,5'd10,5'd18,5'd10},
    // 9
    {5'd2,5'd2,5'd18,5'd2}, {5'd2,5'd2,5'd2,5'd10}, {5'd2,5'd10,5'd18,5'd10},
    {5'd18,5'd2,5'd18,5'd18}, {5'd2,5'd18,5'd18,5'd18},
    // dot
    {5'd8,5'd17,5'd12,5'd17}, {5'd12,5'd17,5'd12,5'd19}, {5'd12,5'd19,5'd8,5'd19},
    {5'd8,5'd19,5'd8,5'd17},
    // plus
    {5'd4,5'd10,5'd16,5'd10}, {5'd10,5'd4,5'd10,5'd16},
    // minus
    {5'd4,5'd10,5'd16,5'd10},
    // x
    {5'd4,5'd4,5'd16,5'd16}, {5'd4,5'd16,5'd16,5'd4},
    // slash
    {5'd4,5'd18,5'd16,5'd2},
    // equals
    {5'd4,5'd8,5'd16,5'd8}, {5'd4,5'd12,5'd16,5'd12},
    // percent
    {5'd1,5'd19,5'd19,5'd1}, {5'd1,5'd1,5'd6,5'd1}, {5'd6,5'd1,5'd6,5'd6},
    {5'd6,5'd6,5'd1,5'd6}, {5'd1,5'd6,5'd1,5'd1}, {5'd14,5'd14,5'd19,5'd14},
    {5'd19,5'd14,5'd19,5'd19}, {5'd19,5'd19,5'd14,5'd19}, {5'd14,5'd19,5'd14,5'd14},
    // r
    {5'd1,5'd11,5'd4,5'd14}, {5'd4,5'd14,5'd8,5'd4}, {5'd8,5'd4,5'd19,5'd4},
    // A
    {5'd2,5'd18,5'd10,5'd2}, {5'd10,5'd2,5'd18,5'd18}, {5'd5,5'd12,5'd15,5'd12},
    // N
    {5'd2,5'd2,5'd2,5'd18}, {5'd18,5'd2,5'd18,5'd18}, {5'd2,5'd2,5'd18,5'd18},
    // S
    {5'd2,5'd2,5'd18,5'd2}, {5'd2,5'd2,5'd2,5'd10}, {5'd2,5'd10,5'd18,5'd10},
    {5'd18,5'd10,5'd18,5'd18}, {5'd2,5'd18,5'd18,5'd18},
    // C
    {5'd2,5'd2,5'd18,5'd2}, {5'd2,5'd2,5'd2,5'd18}, {5'd2,5'd18,5'd18,5'd18}
  };

  function automatic glyph_info_t glyph_lookup(input logic [7:0] code);
    glyph_info_t g;
    g = '0;
    g.known = 1'b1;
    case (code)
      8'h30: begin g.first = 7'd0;  g.count = 4'd4; end  // 0
      8'h31: begin g.first = 7'd4;  g.count = 4'd3; end  // 1
      8'h32: begin g.first = 7'd7;  g.count = 4'd4; end  // 2
      8'h33: begin g.first = 7'd11; g.count = 4'd5; end  // 3
      8'h34: begin g.first = 7'd16; g.count = 4'd3; end  // 4
      8'h35: begin g.first = 7'd19; g.count = 4'd5; end  // 5
      8'h36: begin g.first = 7'd24; g.count = 4'd5; end  // 6
      8'h37: begin g.first = 7'd29; g.count = 4'd2; end  // 7
      8'h38: begin g.first = 7'd31; g.count = 4'd5; end  // 8
      8'h39: begin g.first = 7'd36; g.count = 4'd5; end  // 9
      8'h2E: begin g.first = 7'd41; g.count = 4'd4; g.dot = 1'b1; end  // dot
      8'h2B: begin g.first = 7'd45; g.count = 4'd2; end  // plus
      8'h2D: begin g.first = 7'd47; g.count = 4'd1; end  // minus
      8'h78: begin g.first = 7'd48; g.count = 4'd2; end  // x
      8'h2F: begin g.first = 7'd50; g.count = 4'd1; end  // slash
      8'h3D: begin g.first = 7'd51; g.count = 4'd2; end  // equals
      8'h25: begin g.first = 7'd53; g.count = 4'd9; end  // percent
      8'h72: begin g.first = 7'd62; g.count = 4'd3; end  // r
      8'h41: begin g.first = 7'd65; g.count = 4'd3; end  // A
      8'h4E: begin g.first = 7'd68; g.count = 4'd3; end  // N
      8'h53: begin g.first = 7'd71; g.count = 4'd5; end  // S
      8'h43: begin g.first = 7'd76; g.count = 4'd3; end  // C
      default: g.known = 1'b0;
    endcase
    return g;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/sgg_unit.sv -----
`timescale 1ns / 1ps
// shared multiplier: scale-and-bias step and divide-by-five step
module sgg_unit import sgg_pkg::*; (
  input  unit_req_t   req,
  output logic [16:0] res
);

  logic [15:0] mul_a;
  logic [14:0] mul_b;
  logic [30:0] prod;

  assign prod = 31'(mul_a) * 31'(mul_b);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    res   = '0;
    case (req.op)
      OP_MULADD: begin
        // factor * scale + bias, at most 19 * 4095 + 10
        mul_a = 16'(req.factor);
        mul_b = 15'(req.scale);
        res   = prod[16:0] + 17'(req.bias);
      end
      OP_DIV5: begin
        mul_a = DIV5_RECIP;
        mul_b = req.dividend;
        res   = 17'(prod[30:DIV5_SHIFT]);
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/stroke_glyph_generator.sv -----
`timescale 1ns / 1ps
// top level of the stroke glyph generator: sequencer, config registers, result words
//
// A character is taken when start is high and busy is low. Known characters
// (0-9 . + - x / = % r A N S C) give one result word per stroke, in stroke order,
// each on the result ports for a single cycle with result_valid high; last marks
// the final stroke. The receiver cannot hold results off, so it must take each
// word in the cycle it is shown. All arithmetic runs through one shared
// multiplier, used twice per coordinate (scale times table value, then divide by
// five through a reciprocal). A known character keeps busy high from the accept
// through the advance steps and, for each of its strokes (up to 9), four
// coordinate steps and an emit; no new character is taken meanwhile. An unknown code
// gives a single word with has_segment low in the cycle after the accept and never
// raises busy. Configuration words may be written at any time through the cfg
// channel (cfg_ready is always high) but should only be written while idle.
// Color words are taken and dropped: no port carries them.
module stroke_glyph_generator import sgg_pkg::*; #(
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic               clk,
  input  logic               rst,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         glyph_code,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  // result side
  output logic               result_valid,
  output logic               has_segment,
  output logic signed [15:0] start_x,
  output logic signed [15:0] start_y,
  output logic signed [15:0] end_x,
  output logic signed [15:0] end_y,
  output logic signed [15:0] box_min_x,
  output logic signed [15:0] box_min_y,
  output logic signed [15:0] box_max_x,
  output logic signed [15:0] box_max_y,
  output logic [12:0]        advance,
  output logic               last
);

  // 1.5 rounded half up onto the fixed-point grid
  localparam int PAD_CONST = ((3 << COORD_FRAC_BITS) + 1) >> 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV_MUL,
    ST_ADV_DIV,
    ST_CO_MUL,
    ST_CO_DIV,
    ST_EMIT
  } state_t;

  state_t state;

  // config registers
  logic [11:0] scale;
  logic [7:0]  line_width;

  // per-character working registers
  logic signed [15:0] ox;
  logic signed [15:0] oy;
  logic [6:0]         seg_ptr;
  logic [3:0]         seg_left;
  logic               dot;
  logic [1:0]         k;          // coordinate in flight: x0, y0, x1, y1
  logic [16:0]        acc;
  logic signed [16:0] crd [4];
  logic [12:0]        adv;

  glyph_info_t        lk;
  unit_req_t          req;
  logic [16:0]        res;
  logic [19:0]        seg_word;
  logic [4:0]         tval;
  logic signed [16:0] origin_sel;
  logic signed [16:0] placed;
  logic [9:0]         pad;
  logic signed [16:0] min_x, min_y, max_x, max_y;
  logic signed [17:0] bmin_x, bmin_y, bmax_x, bmax_y;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // config write, upper data bits dropped, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= 12'd256;
      line_width <= 8'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCALE:      scale      <= cfg_data;
        REG_LINE_WIDTH: line_width <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign lk = glyph_lookup(glyph_code);

  // table value for the coordinate in flight
  assign seg_word = SEG_TAB[seg_ptr];
  always_comb begin
    case (k)
      2'd0:    tval = seg_word[19:15];
      2'd1:    tval = seg_word[14:10];
      2'd2:    tval = seg_word[9:5];
      default: tval = seg_word[4:0];
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    req       = '0;
    req.scale = scale;
    case (state)
      ST_ADV_MUL: begin
        req.op     = OP_MULADD;
        req.factor = dot ? 5'd6 : 5'd11;
        req.bias   = 4'd5;
      end
      ST_ADV_DIV: begin
        // (tenths * scale + 5) / 10 as ((...) >> 1) / 5
        req.op       = OP_DIV5;
        req.dividend = acc[15:1];
      end
      ST_CO_MUL: begin
        req.op     = OP_MULADD;
        req.factor = tval;
        req.bias   = 4'd10;
      end
      ST_CO_DIV: begin
        // (t * scale + 10) / 20 as ((...) >> 2) / 5
        req.op       = OP_DIV5;
        req.dividend = acc[16:2];
      end
      default: begin
        req.op = OP_MULADD;
      end
    endcase
  end

  sgg_unit u_unit (
    .req (req),
    .res (res)
  );

  // even coordinates are x, odd are y
  assign origin_sel = k[0] ? 17'(oy) : 17'(ox);
  assign placed     = origin_sel + $signed({5'b0, res[11:0]});

  // box from unclipped endpoints, then saturated on its own
  assign pad    = 10'(line_width) + 10'(PAD_CONST);
  assign min_x  = (crd[0] < crd[2]) ? crd[0] : crd[2];
  assign max_x  = (crd[0] > crd[2]) ? crd[0] : crd[2];
  assign min_y  = (crd[1] < crd[3]) ? crd[1] : crd[3];
  assign max_y  = (crd[1] > crd[3]) ? crd[1] : crd[3];
  assign bmin_x = 18'(min_x) - $signed({8'b0, pad});
  assign bmin_y = 18'(min_y) - $signed({8'b0, pad});
  assign bmax_x = 18'(max_x) + $signed({8'b0, pad});
  assign bmax_y = 18'(max_y) + $signed({8'b0, pad});

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (lk.known) begin
              ox       <= origin_x;
              oy       <= origin_y;
              seg_ptr  <= lk.first;
              seg_left <= lk.count;
              dot      <= lk.dot;
              state    <= ST_ADV_MUL;
            end else begin
              // unknown code: one empty word, half-scale advance
              result_valid <= 1'b1;
              has_segment  <= 1'b0;
              start_x      <= '0;
              start_y      <= '0;
              end_x        <= '0;
              end_y        <= '0;
              box_min_x    <= '0;
              box_min_y    <= '0;
              box_max_x    <= '0;
              box_max_y    <= '0;
              advance      <= 13'((14'(scale) + 14'd1) >> 1);
              last         <= 1'b1;
            end
          end
        end
        ST_ADV_MUL: begin
          acc   <= res;
          state <= ST_ADV_DIV;
        end
        ST_ADV_DIV: begin
          adv   <= res[12:0];
          k     <= 2'd0;
          state <= ST_CO_MUL;
        end
        ST_CO_MUL: begin
          acc   <= res;
          state <= ST_CO_DIV;
        end
        ST_CO_DIV: begin
          crd[k] <= placed;
          if (k == 2'd3) begin
            state <= ST_EMIT;
          end else begin
            k     <= k + 2'd1;
            state <= ST_CO_MUL;
          end
        end
        ST_EMIT: begin
          result_valid <= 1'b1;
          has_segment  <= 1'b1;
          start_x      <= sat16(18'(crd[0]));
          start_y      <= sat16(18'(crd[1]));
          end_x        <= sat16(18'(crd[2]));
          end_y        <= sat16(18'(crd[3]));
          box_min_x    <= sat16(bmin_x);
          box_min_y    <= sat16(bmin_y);
          box_max_x    <= sat16(bmax_x);
          box_max_y    <= sat16(bmax_y);
          advance      <= adv;
          last         <= (seg_left == 4'd1);
          seg_left     <= seg_left - 4'd1;
          seg_ptr      <= seg_ptr + 7'd1;
          k            <= 2'd0;
          state        <= (seg_left == 4'd1) ? ST_IDLE : ST_CO_MUL;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // empty word always closes its character
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !has_segment |-> last)
    else $error("empty result word without last");

  // a known character keeps the block busy
  a_known_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && lk.known |=> busy)
    else $error("known glyph accepted but block not busy");

  // every emit cycle shows a word next cycle
  a_emit_shows_word: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |=> result_valid && has_segment)
    else $error("emit without result word");

  // more strokes follow a word that is not last
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("non-final word but sequencer idle");

  // padded box reaches past the clipped segment on the low x side and the high y side
  a_box_encloses: assert property (@(posedge clk) disable iff (rst)
    result_valid && has_segment |->
      box_min_x <= start_x && box_min_x <= end_x &&
      box_max_y >= start_y && box_max_y >= end_y)
    else $error("bounding box does not enclose segment");

endmodule

// ----- tb/stroke_glyph_generator_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the stroke glyph generator: directed glyphs, random glyphs, config sweeps
module stroke_glyph_generator_tb import sgg_pkg::*;;

  localparam int FRAC_BITS     = 4;
  localparam int CYCLE_LIMIT   = 200000;
  // covers the longest busy stretch, a full percent glyph of nine strokes
  localparam int SETTLE_CYCLES = 90;
  localparam int REPORT_MAX    = 10;

  // spare register slots, writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // every known character, one byte each
  localparam logic [8*22-1:0] GLYPH_SET = "0123456789.+-x/=%rANSC";

  // stroke endpoints in twentieths of the cell, four numbers per stroke: x0 y0 x1 y1
  localparam int STROKE_PTS [316] = '{
    2,2,18,2,   18,2,18,18,  18,18,2,18,  2,18,2,2,                      // 0
    10,1,10,19, 6,4,10,1,    6,19,14,19,                                 // 1
    2,2,18,2,   18,2,18,10,  18,10,2,18,  2,18,18,18,                    // 2
    2,2,18,2,   18,2,18,10,  8,10,18,10,  18,10,18,18, 2,18,18,18,       // 3
    2,2,2,10,   2,10,18,10,  14,2,14,19,                                 // 4
    2,2,18,2,   2,2,2,10,    2,10,18,10,  18,10,18,18, 2,18,18,18,       // 5
    2,2,18,2,   2,2,2,18,    2,10,18,10,  18,10,18,18, 2,18,18,18,       // 6
    2,2,18,2,   18,2,6,18,                                               // 7
    2,2,18,2,   18,2,18,18,  18,18,2,18,  2,18,2,2,    2,10,18,10,       // 8
    2,2,18,2,   2,2,2,10,    2,10,18,10,  18,2,18,18,  2,18,18,18,       // 9
    8,17,12,17, 12,17,12,19, 12,19,8,19,  8,19,8,17,                     // dot
    4,10,16,10, 10,4,10,16,                                              // plus
    4,10,16,10,                                                          // minus
    4,4,16,16,  4,16,16,4,                                               // x
    4,18,16,2,                                                           // slash
    4,8,16,8,   4,12,16,12,                                              // equals
    1,19,19,1,  1,1,6,1,     6,1,6,6,     6,6,1,6,     1,6,1,1,          // percent
    14,14,19,14, 19,14,19,19, 19,19,14,19, 14,19,14,14,
    1,11,4,14,  4,14,8,4,    8,4,19,4,                                   // r
    2,18,10,2,  10,2,18,18,  5,12,15,12,                                 // A
    2,2,2,18,   18,2,18,18,  2,2,18,18,                                  // N
    2,2,18,2,   2,2,2,10,    2,10,18,10,  18,10,18,18, 2,18,18,18,       // S
    2,2,18,2,   2,2,2,18,    2,18,18,18                                  // C
  };

  typedef struct packed {
    logic       known;
    logic [6:0] first;
    logic [3:0] count;
    logic [3:0] tenths;
  } glyph_ref_t;

  // one result word as it should appear on the result ports
  typedef struct packed {
    logic               has_seg;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic [12:0]        adv;
    logic               tail;
  } stroke_word_t;

  // one character waiting to be sent; hold makes the sender wait for a drained pipe
  typedef struct packed {
    logic [7:0]  code;
    logic [15:0] ox;
    logic [15:0] oy;
    logic        hold;
  } glyph_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               start = 1'b0;
  logic               busy;
  logic [7:0]         glyph_code = '0;
  logic signed [15:0] origin_x = '0;
  logic signed [15:0] origin_y = '0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  logic               result_valid;
  logic               has_segment;
  logic signed [15:0] start_x, start_y, end_x, end_y;
  logic signed [15:0] box_min_x, box_min_y, box_max_x, box_max_y;
  logic [12:0]        advance;
  logic               last;

  // mirror of the block's registers
  int         cell_scale = 256;
  int         pen_width = 16;
  logic [7:0] pen_rgba [4] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};

  glyph_cmd_t   glyph_backlog [$];
  stroke_word_t strokes_due [$];
  int           gap_pct = 0;
  int           mismatches = 0;
  int           words_seen = 0;
  int           cycle_count = 0;

  stroke_glyph_generator #(.COORD_FRAC_BITS(FRAC_BITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .glyph_code   (glyph_code),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .has_segment  (has_segment),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .box_min_x    (box_min_x),
    .box_min_y    (box_min_y),
    .box_max_x    (box_max_x),
    .box_max_y    (box_max_y),
    .advance      (advance),
    .last         (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic glyph_ref_t find_glyph(input logic [7:0] code);
    glyph_ref_t g;
    g = '{known: 1'b1, first: 7'd0, count: 4'd0, tenths: 4'd11};
    case (code)
      "0": begin g.first = 7'd0;  g.count = 4'd4; end
      "1": begin g.first = 7'd4;  g.count = 4'd3; end
      "2": begin g.first = 7'd7;  g.count = 4'd4; end
      "3": begin g.first = 7'd11; g.count = 4'd5; end
      "4": begin g.first = 7'd16; g.count = 4'd3; end
      "5": begin g.first = 7'd19; g.count = 4'd5; end
      "6": begin g.first = 7'd24; g.count = 4'd5; end
      "7": begin g.first = 7'd29; g.count = 4'd2; end
      "8": begin g.first = 7'd31; g.count = 4'd5; end
      "9": begin g.first = 7'd36; g.count = 4'd5; end
      ".": begin g.first = 7'd41; g.count = 4'd4; g.tenths = 4'd6; end  // narrow advance
      "+": begin g.first = 7'd45; g.count = 4'd2; end
      "-": begin g.first = 7'd47; g.count = 4'd1; end
      "x": begin g.first = 7'd48; g.count = 4'd2; end
      "/": begin g.first = 7'd50; g.count = 4'd1; end
      "=": begin g.first = 7'd51; g.count = 4'd2; end
      "%": begin g.first = 7'd53; g.count = 4'd9; end
      "r": begin g.first = 7'd62; g.count = 4'd3; end
      "A": begin g.first = 7'd65; g.count = 4'd3; end
      "N": begin g.first = 7'd68; g.count = 4'd3; end
      "S": begin g.first = 7'd71; g.count = 4'd5; end
      "C": begin g.first = 7'd76; g.count = 4'd3; end
      default: g.known = 1'b0;
    endcase
    return g;
  endfunction

  function automatic logic signed [15:0] clip16(input int v);
    logic signed [15:0] r;
    if (v > 32767) begin
      r = 16'sh7FFF;
    end else if (v < -32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // table value in twentieths to pixels, rounded half up, then offset by the origin
  function automatic int place(input int origin, input int t);
    return origin + (t * cell_scale + 10) / 20;
  endfunction

  // expected words for one accepted character, appended in stroke order
  task automatic draw_glyph(input logic [7:0] code, input logic signed [15:0] ox,
                            input logic signed [15:0] oy);
    glyph_ref_t   g;
    stroke_word_t w;
    int           pad, adv, base, x0, y0, x1, y1;
    g = find_glyph(code);
    pad = pen_width + (((3 << FRAC_BITS) + 1) >> 1);
    if (!g.known) begin
      // unknown character: a lone empty word with half the cell as advance
      w = '0;
      adv = (cell_scale + 1) / 2;
      w.adv = adv[12:0];
      w.tail = 1'b1;
      strokes_due.push_back(w);
    end else begin
      adv = (int'(g.tenths) * cell_scale + 5) / 10;
      for (int i = 0; i < int'(g.count); i++) begin
        base = (int'(g.first) + i) * 4;
        x0 = place(int'(ox), STROKE_PTS[base]);
        y0 = place(int'(oy), STROKE_PTS[base + 1]);
        x1 = place(int'(ox), STROKE_PTS[base + 2]);
        y1 = place(int'(oy), STROKE_PTS[base + 3]);
        w.has_seg = 1'b1;
        w.sx = clip16(x0);
        w.sy = clip16(y0);
        w.ex = clip16(x1);
        w.ey = clip16(y1);
        // box comes from the unclipped endpoints and is clipped on its own
        w.min_x = clip16(((x0 < x1) ? x0 : x1) - pad);
        w.min_y = clip16(((y0 < y1) ? y0 : y1) - pad);
        w.max_x = clip16(((x0 > x1) ? x0 : x1) + pad);
        w.max_y = clip16(((y0 > y1) ? y0 : y1) + pad);
        w.adv = adv[12:0];
        w.tail = (i == int'(g.count) - 1);
        strokes_due.push_back(w);
      end
    end
  endtask

  function automatic void show_word(input string tag, input stroke_word_t w);
    $display("  %s seg=%0b start=(%0d,%0d) end=(%0d,%0d) box=(%0d,%0d)..(%0d,%0d) adv=%0d last=%0b",
             tag, w.has_seg, w.sx, w.sy, w.ex, w.ey, w.min_x, w.min_y, w.max_x, w.max_y,
             w.adv, w.tail);
  endfunction

  // ---------------------------------------------------------------------------
  // command driver
  // ---------------------------------------------------------------------------

  // start stays up until busy is seen low at an edge; a new word is loaded in the
  // same step the old one is taken, so start never drops between back-to-back words
  always @(posedge clk) begin : command_driver
    glyph_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        draw_glyph(glyph_code, origin_x, origin_y);
      end
      if (!start || !busy) begin
        // a held word waits until the last expected word has gone by; the
        // result_valid term keeps this independent of the monitor's pop order
        if (glyph_backlog.size() != 0 && $urandom_range(99) >= gap_pct &&
            !(glyph_backlog[0].hold && (strokes_due.size() != 0 || result_valid))) begin
          nxt = glyph_backlog.pop_front();
          start      <= 1'b1;
          glyph_code <= nxt.code;
          origin_x   <= nxt.ox;
          origin_y   <= nxt.oy;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------------

  // results cannot be held off, every strobe is a word to check
  always @(posedge clk) begin : result_monitor
    stroke_word_t seen, want;
    if (!rst && result_valid) begin
      seen = '{has_segment, start_x, start_y, end_x, end_y,
               box_min_x, box_min_y, box_max_x, box_max_y, advance, last};
      words_seen++;
      if (strokes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("word %0d arrived with nothing expected", words_seen);
          show_word("actual  ", seen);
        end
      end else begin
        want = strokes_due.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("word %0d mismatch", words_seen);
            show_word("expected", want);
            show_word("actual  ", seen);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // register write; the mirror follows at the edge where the write is taken
  task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SCALE:       cell_scale = int'(data);
      REG_LINE_WIDTH:  pen_width = int'(data[7:0]);  // upper bits dropped
      REG_COLOR_RED:   pen_rgba[0] = data[7:0];
      REG_COLOR_GREEN: pen_rgba[1] = data[7:0];
      REG_COLOR_BLUE:  pen_rgba[2] = data[7:0];
      REG_COLOR_ALPHA: pen_rgba[3] = data[7:0];
      default: ;  // spare slots hold nothing
    endcase
  endtask

  // wait for an empty pipe, then let the block finish any stroke still in flight
  task automatic settle();
    do @(posedge clk);
    while (glyph_backlog.size() != 0 || start || strokes_due.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_glyph(input logic [7:0] code, input logic [15:0] ox,
                             input logic [15:0] oy, input logic hold);
    glyph_cmd_t c;
    c = '{code: code, ox: ox, oy: oy, hold: hold};
    glyph_backlog.push_back(c);
  endtask

  // origins cluster near zero and near both rails so clipping shows up often
  function automatic logic [15:0] random_origin();
    logic [15:0] v;
    case ($urandom_range(3))
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(4095)) - 16'd2048;
      2: v = 16'h7FFF - 16'($urandom_range(1023));
      default: v = 16'h8000 + 16'($urandom_range(1023));
    endcase
    return v;
  endfunction

  // mostly known characters, with a share of arbitrary codes as noise
  task automatic random_phase(input int count, input int idle_pct);
    int          k;
    logic [7:0]  code;
    gap_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 80) begin
        k = $urandom_range(21);
        code = GLYPH_SET[8*k +: 8];
      end else begin
        code = 8'($urandom_range(255));
      end
      queue_glyph(code, random_origin(), random_origin(),
                  (i == 4) || ($urandom_range(19) == 0));
    end
    settle();
  endtask

  task automatic shuffle_regs();
    write_reg(REG_SCALE, 12'($urandom_range(4095)));
    write_reg(REG_LINE_WIDTH, 12'($urandom));
    write_reg(REG_COLOR_RED, 12'($urandom));
    write_reg(REG_COLOR_GREEN, 12'($urandom));
    write_reg(REG_COLOR_BLUE, 12'($urandom));
    write_reg(REG_COLOR_ALPHA, 12'($urandom));
    write_reg(($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO, 12'($urandom));
  endtask

  // run-length guard
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : sequencer
    logic [15:0] dx, dy;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed pass at reset settings: every glyph once, origins cycling
    // through zero, both rails and a mixed corner
    gap_pct = 0;
    for (int k = 0; k < 22; k++) begin
      case (k % 4)
        0: begin dx = 16'h0000; dy = 16'h0000; end
        1: begin dx = 16'h7FFF; dy = 16'h7FFF; end
        2: begin dx = 16'h8000; dy = 16'h8000; end
        default: begin dx = 16'h7F00; dy = 16'h80F0; end
      endcase
      queue_glyph(GLYPH_SET[8*k +: 8], dx, dy, 1'b0);
    end
    // unknown codes: lowest, highest, and one that differs from a known letter only in case
    queue_glyph(8'h00, 16'h0000, 16'h0000, 1'b0);
    queue_glyph(8'hFF, 16'h7FFF, 16'h8000, 1'b0);
    queue_glyph(8'h58, 16'h8000, 16'h7FFF, 1'b1);
    settle();

    // largest cell and pen; the width write carries bits above the register
    write_reg(REG_SCALE, 12'hFFF);
    write_reg(REG_LINE_WIDTH, 12'hFFF);
    write_reg(REG_COLOR_RED, 12'h0A5);
    write_reg(REG_COLOR_GREEN, 12'h15A);
    write_reg(REG_COLOR_BLUE, 12'hF00);
    write_reg(REG_COLOR_ALPHA, 12'h0FF);
    write_reg(REG_SPARE_LO, 12'hFFF);
    write_reg(REG_SPARE_HI, 12'h555);
    random_phase(20, 74);

    // zero cell and pen: every stroke collapses onto the origin
    write_reg(REG_SCALE, 12'h000);
    write_reg(REG_LINE_WIDTH, 12'hF00);
    write_reg(REG_COLOR_RED, 12'h000);
    write_reg(REG_COLOR_GREEN, 12'h000);
    write_reg(REG_COLOR_BLUE, 12'h000);
    write_reg(REG_COLOR_ALPHA, 12'h000);
    random_phase(15, 10);

    shuffle_regs();
    random_phase(20, 0);

    shuffle_regs();
    random_phase(20, 74);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
